>>> rtl/core/lgmd_pkg.sv
`timescale 1ns / 1ps

package lgmd_pkg;

  localparam int unsigned LimitWidth = 16;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_FWD  = 2'd1;
  localparam logic [1:0] MODE_REV  = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam logic [LimitWidth-1:0] LIMIT_RESET = 16'd6000;
  localparam logic [LimitWidth-1:0] LIMIT_MAX   = 16'hFFFF;

  localparam logic REG_RUN_LIMIT = 1'b0;

  typedef struct packed {
    logic       top_pressed;
    logic       bottom_pressed;
    logic       request_valid;
    logic [1:0] request_dir;
  } tick_t;

  typedef struct packed {
    logic       drive_forward;
    logic       drive_reverse;
    logic [1:0] motor_mode;
    logic       any_limit_led;
    logic       top_latched;
    logic       bottom_latched;
    logic       limit_stop;
    logic       timeout_stop;
    logic       request_refused;
    logic       status_event;
  } result_t;

endpackage

>>> rtl/core/lgmd_tick_if.sv
`timescale 1ns / 1ps

interface lgmd_tick_if;
  logic       valid;
  logic       ready;
  logic       top_pressed;
  logic       bottom_pressed;
  logic       request_valid;
  logic [1:0] request_dir;

  modport source (
    output valid, top_pressed, bottom_pressed, request_valid, request_dir,
    input  ready
  );
  modport sink (
    input  valid, top_pressed, bottom_pressed, request_valid, request_dir,
    output ready
  );
endinterface

>>> rtl/core/lgmd_result_if.sv
`timescale 1ns / 1ps

interface lgmd_result_if;
  logic       valid;
  logic       ready;
  logic       drive_forward;
  logic       drive_reverse;
  logic [1:0] motor_mode;
  logic       any_limit_led;
  logic       top_latched;
  logic       bottom_latched;
  logic       limit_stop;
  logic       timeout_stop;
  logic       request_refused;
  logic       status_event;

  modport source (
    output valid, drive_forward, drive_reverse, motor_mode, any_limit_led,
           top_latched, bottom_latched, limit_stop, timeout_stop,
           request_refused, status_event,
    input  ready
  );
  modport sink (
    input  valid, drive_forward, drive_reverse, motor_mode, any_limit_led,
           top_latched, bottom_latched, limit_stop, timeout_stop,
           request_refused, status_event,
    output ready
  );
endinterface

>>> rtl/core/limit_guarded_motor_direction_control_core.sv
`timescale 1ns / 1ps
// A word accepted on tick is held in the input register, then stepped into
// the result register. Throughput: one word per cycle while result is not
// stalled, set by the combinational step between these two registers.
// Reset (rst, synchronous): motor idle, request and limits cleared,
// run timer stopped, run_limit_ticks back to 6000.

module limit_guarded_motor_direction_control_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  lgmd_tick_if.sink            tick,
  lgmd_result_if.source        result
);

  logic                            in_valid;
  lgmd_pkg::tick_t                 in_word;
  logic                            advance;
  logic                            out_valid;
  lgmd_pkg::result_t               out_word;
  lgmd_pkg::result_t               step_result;
  logic [lgmd_pkg::LimitWidth-1:0] run_limit_ticks;

  lgmd_cfg u_cfg (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .run_limit_ticks (run_limit_ticks)
  );

  assign advance    = in_valid && (!out_valid || result.ready);
  assign tick.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.ready && tick.valid) begin
      in_word.top_pressed    <= tick.top_pressed;
      in_word.bottom_pressed <= tick.bottom_pressed;
      in_word.request_valid  <= tick.request_valid;
      in_word.request_dir    <= tick.request_dir;
    end
  end

  lgmd_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .step_en         (advance),
    .tick            (in_word),
    .run_limit_ticks (run_limit_ticks),
    .result          (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= step_result;
    end
  end

  assign result.valid           = out_valid;
  assign result.drive_forward   = out_word.drive_forward;
  assign result.drive_reverse   = out_word.drive_reverse;
  assign result.motor_mode      = out_word.motor_mode;
  assign result.any_limit_led   = out_word.any_limit_led;
  assign result.top_latched     = out_word.top_latched;
  assign result.bottom_latched  = out_word.bottom_latched;
  assign result.limit_stop      = out_word.limit_stop;
  assign result.timeout_stop    = out_word.timeout_stop;
  assign result.request_refused = out_word.request_refused;
  assign result.status_event    = out_word.status_event;

endmodule

>>> rtl/core/lgmd_cfg.sv
`timescale 1ns / 1ps

module lgmd_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  output logic [lgmd_pkg::LimitWidth-1:0]     run_limit_ticks
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == lgmd_pkg::REG_RUN_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_limit_ticks <= lgmd_pkg::LIMIT_RESET;
    end else if (wr_en) begin
      run_limit_ticks <= pwdata[lgmd_pkg::LimitWidth-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == lgmd_pkg::REG_RUN_LIMIT) begin
      prdata = {{(32 - lgmd_pkg::LimitWidth){1'b0}}, run_limit_ticks};
    end else begin
      prdata = 32'd0;
    end
  end

endmodule

>>> rtl/core/lgmd_ctrl.sv
`timescale 1ns / 1ps

module lgmd_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step_en,
  input  lgmd_pkg::tick_t                 tick,
  input  logic [lgmd_pkg::LimitWidth-1:0] run_limit_ticks,
  output lgmd_pkg::result_t               result
);

  logic [1:0]                      motor_now;
  logic [1:0]                      motor_wanted;
  logic                            top_active;
  logic                            bottom_active;
  logic [lgmd_pkg::LimitWidth-1:0] run_elapsed;
  logic                            timing_on;

  logic [1:0]                      motor_now_next;
  logic [1:0]                      motor_wanted_next;
  logic [lgmd_pkg::LimitWidth-1:0] run_elapsed_next;
  logic                            timing_on_next;

  logic [1:0]                      wanted_req;
  logic                            top_chg;
  logic                            bot_chg;
  logic                            lim_top;
  logic                            lim_bot;
  logic                            lim_stop;
  logic [1:0]                      mode_after_top;
  logic [1:0]                      now_lim;
  logic [1:0]                      wanted_lim;
  logic                            timing_lim;
  logic                            running;
  logic [lgmd_pkg::LimitWidth-1:0] elapsed_inc;
  logic                            to_stop;
  logic                            refused;
  logic                            taken;

  always_comb begin
    if (tick.request_valid && (tick.request_dir != lgmd_pkg::MODE_NONE)) begin
      wanted_req = tick.request_dir;
    end else begin
      wanted_req = motor_wanted;
    end

    top_chg        = tick.top_pressed != top_active;
    bot_chg        = tick.bottom_pressed != bottom_active;
    lim_top        = top_chg && tick.top_pressed && (motor_now == lgmd_pkg::MODE_FWD);
    mode_after_top = lim_top ? lgmd_pkg::MODE_IDLE : motor_now;
    lim_bot        = bot_chg && tick.bottom_pressed && (mode_after_top == lgmd_pkg::MODE_REV);
    lim_stop       = lim_top || lim_bot;

    now_lim    = lim_stop ? lgmd_pkg::MODE_IDLE : motor_now;
    wanted_lim = lim_stop ? lgmd_pkg::MODE_IDLE : wanted_req;
    timing_lim = lim_stop ? 1'b0 : timing_on;

    running = timing_lim &&
              ((now_lim == lgmd_pkg::MODE_FWD) || (now_lim == lgmd_pkg::MODE_REV));
    if (run_elapsed == lgmd_pkg::LIMIT_MAX) begin
      elapsed_inc = run_elapsed;
    end else begin
      elapsed_inc = run_elapsed + 1'b1;
    end
    to_stop = running && (elapsed_inc >= run_limit_ticks);

    motor_now_next    = now_lim;
    motor_wanted_next = wanted_lim;
    timing_on_next    = timing_lim;
    run_elapsed_next  = running ? elapsed_inc : run_elapsed;
    refused           = 1'b0;
    taken             = 1'b0;

    if (to_stop) begin
      motor_now_next    = lgmd_pkg::MODE_IDLE;
      motor_wanted_next = lgmd_pkg::MODE_IDLE;
      timing_on_next    = 1'b0;
    end else if (wanted_lim != now_lim) begin
      if ((wanted_lim == lgmd_pkg::MODE_FWD) && tick.top_pressed) begin
        motor_wanted_next = lgmd_pkg::MODE_IDLE;
        refused           = 1'b1;
      end else if ((wanted_lim == lgmd_pkg::MODE_REV) && tick.bottom_pressed) begin
        motor_wanted_next = lgmd_pkg::MODE_IDLE;
        refused           = 1'b1;
      end else begin
        motor_now_next = wanted_lim;
        taken          = 1'b1;
        if (wanted_lim == lgmd_pkg::MODE_IDLE) begin
          timing_on_next = 1'b0;
        end else begin
          run_elapsed_next = '0;
          timing_on_next   = 1'b1;
        end
      end
    end

    result.drive_forward   = motor_now_next == lgmd_pkg::MODE_FWD;
    result.drive_reverse   = motor_now_next == lgmd_pkg::MODE_REV;
    result.motor_mode      = motor_now_next;
    result.any_limit_led   = tick.top_pressed || tick.bottom_pressed;
    result.top_latched     = tick.top_pressed;
    result.bottom_latched  = tick.bottom_pressed;
    result.limit_stop      = lim_stop;
    result.timeout_stop    = to_stop;
    result.request_refused = refused;
    result.status_event    = top_chg || bot_chg || to_stop || refused || taken;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_now     <= lgmd_pkg::MODE_IDLE;
      motor_wanted  <= lgmd_pkg::MODE_IDLE;
      top_active    <= 1'b0;
      bottom_active <= 1'b0;
      run_elapsed   <= '0;
      timing_on     <= 1'b0;
    end else if (step_en) begin
      motor_now     <= motor_now_next;
      motor_wanted  <= motor_wanted_next;
      top_active    <= tick.top_pressed;
      bottom_active <= tick.bottom_pressed;
      run_elapsed   <= run_elapsed_next;
      timing_on     <= timing_on_next;
    end
  end

  a_timing_tracks_mode: assert property (@(posedge clk) disable iff (rst)
    timing_on == (motor_now != lgmd_pkg::MODE_IDLE))
    else $error("run timer out of step with motor mode");

  a_mode_code: assert property (@(posedge clk) disable iff (rst)
    motor_now != lgmd_pkg::MODE_NONE && motor_wanted != lgmd_pkg::MODE_NONE)
    else $error("motor mode holds unused code");

  a_stop_halts: assert property (@(posedge clk) disable iff (rst)
    step_en && (lim_stop || to_stop) |=> motor_now == lgmd_pkg::MODE_IDLE &&
    motor_wanted == lgmd_pkg::MODE_IDLE)
    else $error("motor still set after stop");

  a_stops_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(to_stop && (lim_stop || refused)))
    else $error("timeout stop overlaps another stop");

endmodule
